@@ rtl/dns_name_label_encoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// dns_name_label_encoder_top_assert.svh
// Assertion macros for the name label encoder. Clock i_clk and reset
// i_rst_n must be in scope where the macros are used.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_ENCODER_TOP_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define DNLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define DNLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dnle_pkg.sv @@
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared constants and types of the name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    // default longest label kept, longer labels are truncated
    localparam int MAX_LABEL_DEF = 63;

    // separator character between labels
    localparam logic [7:0] SEPARATOR = 8'h2E;

    // hash: factor is always a power of two, kept as a shift amount
    localparam int HASH_W        = 32;
    localparam int FACTOR_INIT   = 16;
    localparam int SHAMT_W       = $clog2(HASH_W) + 1;
    localparam logic [SHAMT_W-1:0] SHAMT_INIT = SHAMT_W'($clog2(FACTOR_INIT));

    // label counter saturation
    localparam logic [7:0] LABELS_MAX = 8'hFF;

    // command queue depth
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // zero bytes that follow the label of a command
    typedef enum logic [1:0] {
        TAIL_NONE       = 2'd0,
        TAIL_TERM       = 2'd1,
        TAIL_EMPTY_TERM = 2'd2
    } t_tail;

    // source of one wire byte
    typedef enum logic [1:0] {
        KIND_LEN,
        KIND_DATA,
        KIND_ZERO
    } t_kind;

    // end-of-name summary carried with a command
    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] hash;
        logic [7:0]        count;
        logic              ovf;
    } t_meta;

    // command queue status
    typedef struct packed {
        logic [CMDQ_CNT_W-1:0] count;
        logic                  empty;
        logic                  full;
    } t_q_stat;

endpackage

@@ rtl/dnle_ram.sv @@
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/dnle_front.sv @@
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name bytes, keeps hash and label state, writes label bytes into
// the current buffer bank and issues one emit command per label boundary.
// ----------------------------------------------------------------------------
module dnle_front #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
    parameter int LEN_W     = $clog2(MAX_LABEL + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_name_byte,
    input  logic               i_last_byte,
    input  logic               i_busy_full,
    output logic               o_wr_en,
    output logic [LEN_W:0]     o_wr_addr,
    output logic [7:0]         o_wr_data,
    output logic               o_cmd_push,
    output logic               o_cmd_bank,
    output logic [LEN_W-1:0]   o_cmd_len,
    output dnle_pkg::t_tail    o_cmd_tail,
    output dnle_pkg::t_meta    o_cmd_meta
);

    import dnle_pkg::*;

    logic [LEN_W-1:0]   r_len,    n_len;
    logic [HASH_W-1:0]  r_hash,   n_hash;
    logic [SHAMT_W-1:0] r_shamt,  n_shamt;
    logic [7:0]         r_labels, n_labels;
    logic               r_ovf,    n_ovf;
    logic               r_bank,   n_bank;

    logic               acc;
    logic               is_dot;
    logic               store_ok;
    logic               emit;
    logic [LEN_W-1:0]   len_upd;
    logic [HASH_W-1:0]  sx;
    logic [HASH_W-1:0]  prod;
    logic [HASH_W-1:0]  hash_upd;
    logic               ovf_upd;
    logic [8:0]         labels_sum;
    logic [7:0]         labels_upd;

    // handshake
    assign o_stall = i_busy_full;
    assign acc     = i_valid && !i_busy_full;

    // classify and compute updated name state
    always_comb begin
        is_dot     = (i_name_byte == SEPARATOR);
        store_ok   = (r_len < LEN_W'(MAX_LABEL));
        len_upd    = (!is_dot && store_ok) ? r_len + 1'b1 : r_len;
        sx         = {{(HASH_W-8){i_name_byte[7]}}, i_name_byte};
        prod       = r_shamt[SHAMT_W-1] ? '0 : (sx << r_shamt[SHAMT_W-2:0]);
        hash_upd   = is_dot ? r_hash : r_hash + prod;
        ovf_upd    = r_ovf || (!is_dot && !store_ok);
        labels_sum = {1'b0, r_labels} + 9'(is_dot) + (i_last_byte ? 9'd2 : 9'd0);
        labels_upd = labels_sum[8] ? LABELS_MAX : labels_sum[7:0];
        emit       = acc && (is_dot || i_last_byte);
    end

    // emit command
    always_comb begin
        o_cmd_push      = emit;
        o_cmd_bank      = r_bank;
        o_cmd_len       = is_dot ? r_len : len_upd;
        o_cmd_tail      = !i_last_byte ? TAIL_NONE : (is_dot ? TAIL_EMPTY_TERM : TAIL_TERM);
        o_cmd_meta.done  = i_last_byte;
        o_cmd_meta.hash  = hash_upd;
        o_cmd_meta.count = labels_upd;
        o_cmd_meta.ovf   = ovf_upd;
    end

    // label buffer write
    assign o_wr_en   = acc && !is_dot && store_ok;
    assign o_wr_addr = {r_bank, r_len};
    assign o_wr_data = i_name_byte;

    // next name state
    always_comb begin
        n_len    = r_len;
        n_hash   = r_hash;
        n_shamt  = r_shamt;
        n_labels = r_labels;
        n_ovf    = r_ovf;
        n_bank   = emit ? !r_bank : r_bank;
        if (acc) begin
            if (i_last_byte) begin
                n_len    = '0;
                n_hash   = '0;
                n_shamt  = SHAMT_INIT;
                n_labels = '0;
                n_ovf    = 1'b0;
            end else begin
                n_len    = is_dot ? '0 : len_upd;
                n_hash   = hash_upd;
                n_labels = labels_upd;
                n_ovf    = ovf_upd;
                if (is_dot && !r_shamt[SHAMT_W-1]) begin
                    n_shamt = r_shamt + 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_hash   <= '0;
            r_shamt  <= SHAMT_INIT;
            r_labels <= '0;
            r_ovf    <= 1'b0;
            r_bank   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_hash   <= n_hash;
            r_shamt  <= n_shamt;
            r_labels <= n_labels;
            r_ovf    <= n_ovf;
            r_bank   <= n_bank;
        end
    end

endmodule

@@ rtl/dnle_cmdq.sv @@
// ----------------------------------------------------------------------------
// dnle_cmdq
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module dnle_cmdq #(
    parameter int W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [W-1:0]      i_data,
    input  logic              i_pop,
    output logic [W-1:0]      o_data,
    output dnle_pkg::t_q_stat o_stat
);

    import dnle_pkg::*;

    logic [W-1:0]          r_mem [CMDQ_DEPTH];
    logic                  r_wp,    n_wp;
    logic                  r_rp,    n_rp;
    logic [CMDQ_CNT_W-1:0] r_count, n_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_comb begin
        n_wp    = i_push ? !r_wp : r_wp;
        n_rp    = i_pop ? !r_rp : r_rp;
        n_count = r_count + CMDQ_CNT_W'(i_push) - CMDQ_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));

endmodule

@@ rtl/dnle_back.sv @@
// ----------------------------------------------------------------------------
// dnle_back
// Carries out emit commands: walks the wire bytes of a label one a cycle unless
// stalled, reads label bytes from the buffer, packs up to two per transaction.
// ----------------------------------------------------------------------------
module dnle_back #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
    parameter int LEN_W     = $clog2(MAX_LABEL + 1),
    parameter int POS_W     = $clog2(MAX_LABEL + 3)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  logic              i_cmd_bank,
    input  logic [LEN_W-1:0]  i_cmd_len,
    input  dnle_pkg::t_tail   i_cmd_tail,
    input  dnle_pkg::t_meta   i_cmd_meta,
    output logic              o_cmd_pop,
    output logic              o_busy,
    output logic              o_rd_en,
    output logic [LEN_W:0]    o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_wire_byte_a,
    output logic [7:0]        o_wire_byte_b,
    output logic [1:0]        o_byte_pair_count,
    output logic              o_run_last,
    output logic              o_name_done,
    output logic [31:0]       o_name_hash,
    output logic [7:0]        o_label_count,
    output logic              o_label_overflow
);

    import dnle_pkg::*;

    // byte walker
    logic              r_active;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_last_pos;
    logic              r_bank;
    logic [LEN_W-1:0]  r_len;
    t_meta             r_meta;

    // read stage
    logic              r_s1_valid;
    t_kind             r_s1_kind;
    logic [7:0]        r_s1_byte;
    logic              r_s1_last;
    t_meta             r_s1_meta;

    // pairing stage
    logic              r_pend_valid;
    logic [7:0]        r_pend_byte;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_a;
    logic [7:0]        r_out_b;
    logic [1:0]        r_out_cnt;
    logic              r_out_run_last;
    logic              r_out_done;
    logic [HASH_W-1:0] r_out_hash;
    logic [7:0]        r_out_count;
    logic              r_out_ovf;

    logic              en;
    logic              at_last;
    t_kind             kind0;
    logic [POS_W-1:0]  pos_m1;
    logic [7:0]        s1_data;
    logic              out_load;
    logic              out_pair;

    // whole pipe advances when the output register can take a transaction
    assign en      = !r_out_valid || !i_stall;
    assign at_last = (r_pos == r_last_pos);
    assign pos_m1  = r_pos - 1'b1;

    // byte source of the current position
    always_comb begin
        if (r_pos == '0) begin
            kind0 = KIND_LEN;
        end else if (r_pos <= POS_W'(r_len)) begin
            kind0 = KIND_DATA;
        end else begin
            kind0 = KIND_ZERO;
        end
    end

    assign o_cmd_pop = en && i_cmd_valid && (!r_active || at_last);
    assign o_busy    = r_active;
    assign o_rd_en   = en && r_active && (kind0 == KIND_DATA);
    assign o_rd_addr = {r_bank, pos_m1[LEN_W-1:0]};

    // byte walker control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_cmd_pop) begin
            r_active <= 1'b1;
        end else if (en && r_active && at_last) begin
            r_active <= 1'b0;
        end
    end

    // byte walker payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_pos      <= '0;
            r_last_pos <= POS_W'(i_cmd_len) + POS_W'(i_cmd_tail);
            r_bank     <= i_cmd_bank;
            r_len      <= i_cmd_len;
            r_meta     <= i_cmd_meta;
        end else if (en && r_active) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // read stage, aligned with the buffer read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind <= kind0;
            r_s1_byte <= (kind0 == KIND_LEN) ? 8'(r_len) : 8'h00;
            r_s1_last <= at_last;
            r_s1_meta <= r_meta;
        end
    end

    assign s1_data  = (r_s1_kind == KIND_DATA) ? i_rd_data : r_s1_byte;
    assign out_pair = r_pend_valid;
    assign out_load = en && r_s1_valid && (r_pend_valid || r_s1_last);

    // pairing stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (en && r_s1_valid) begin
            r_pend_valid <= !r_pend_valid && !r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid && !r_pend_valid) begin
            r_pend_byte <= s1_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_a        <= out_pair ? r_pend_byte : s1_data;
            r_out_b        <= out_pair ? s1_data : 8'h00;
            r_out_cnt      <= out_pair ? 2'd2 : 2'd1;
            r_out_run_last <= r_s1_last;
            r_out_done     <= r_s1_last && r_s1_meta.done;
            r_out_hash     <= (r_s1_last && r_s1_meta.done) ? r_s1_meta.hash : '0;
            r_out_count    <= (r_s1_last && r_s1_meta.done) ? r_s1_meta.count : 8'h00;
            r_out_ovf      <= r_s1_last && r_s1_meta.done && r_s1_meta.ovf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_wire_byte_a     = r_out_a;
    assign o_wire_byte_b     = r_out_b;
    assign o_byte_pair_count = r_out_cnt;
    assign o_run_last        = r_out_run_last;
    assign o_name_done       = r_out_done;
    assign o_name_hash       = r_out_hash;
    assign o_label_count     = r_out_count;
    assign o_label_overflow  = r_out_ovf;

endmodule

@@ rtl/dns_name_label_encoder_top.sv @@
// Path: the command for a label is pushed when the byte that closes it is accepted;
// the byte walker pops it, then its wire bytes pass the read stage, the pairing stage
// and the output register. Throughput: plain bytes go in one per cycle while o_stall is
// low; wire bytes come out one per cycle while i_stall does not hold the output, set by
// the single label buffer read port. The front stalls while two labels are queued or in
// emission (two buffer banks). Reset is synchronous, active low, clears the busy and
// valid flags, queue pointers and name state; the label buffer is not cleared.
// ----------------------------------------------------------------------------
// dns_name_label_encoder_top
// Encodes a dotted host name into wire-form labels with name hash and count.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_top #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_name_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_wire_byte_a,
    output logic [7:0]  o_wire_byte_b,
    output logic [1:0]  o_byte_pair_count,
    output logic        o_run_last,
    output logic        o_name_done,
    output logic [31:0] o_name_hash,
    output logic [7:0]  o_label_count,
    output logic        o_label_overflow
);

    import dnle_pkg::*;

    `include "dns_name_label_encoder_top_assert.svh"

    localparam int LEN_W  = $clog2(MAX_LABEL + 1);
    localparam int POS_W  = $clog2(MAX_LABEL + 3);
    localparam int ADDR_W = LEN_W + 1;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        t_tail            tail;
        t_meta            meta;
    } t_cmd;

    localparam int QW = $bits(t_cmd);

    t_cmd              cmd_in;
    t_cmd              cmd_out;
    logic [QW-1:0]     q_rd_data;
    t_q_stat           q_stat;
    logic              cmd_push;
    logic              cmd_pop;
    logic              back_busy;
    logic [2:0]        inflight;
    logic              busy_full;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // labels queued or in emission; both banks taken at two
    assign inflight  = {1'b0, q_stat.count} + 3'(back_busy);
    assign busy_full = (inflight >= 3'd2);

    dnle_front #(
        .MAX_LABEL (MAX_LABEL),
        .LEN_W     (LEN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_name_byte (i_name_byte),
        .i_last_byte (i_last_byte),
        .i_busy_full (busy_full),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_cmd_push  (cmd_push),
        .o_cmd_bank  (cmd_in.bank),
        .o_cmd_len   (cmd_in.len),
        .o_cmd_tail  (cmd_in.tail),
        .o_cmd_meta  (cmd_in.meta)
    );

    dnle_ram #(
        .WIDTH  (8),
        .DEPTH  (2 ** ADDR_W),
        .ADDR_W (ADDR_W)
    ) u_label_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dnle_cmdq #(
        .W (QW)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (q_rd_data),
        .o_stat  (q_stat)
    );

    assign cmd_out = q_rd_data;

    dnle_back #(
        .MAX_LABEL (MAX_LABEL),
        .LEN_W     (LEN_W),
        .POS_W     (POS_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (!q_stat.empty),
        .i_cmd_bank        (cmd_out.bank),
        .i_cmd_len         (cmd_out.len),
        .i_cmd_tail        (cmd_out.tail),
        .i_cmd_meta        (cmd_out.meta),
        .o_cmd_pop         (cmd_pop),
        .o_busy            (back_busy),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr),
        .i_rd_data         (rd_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_wire_byte_a     (o_wire_byte_a),
        .o_wire_byte_b     (o_wire_byte_b),
        .o_byte_pair_count (o_byte_pair_count),
        .o_run_last        (o_run_last),
        .o_name_done       (o_name_done),
        .o_name_hash       (o_name_hash),
        .o_label_count     (o_label_count),
        .o_label_overflow  (o_label_overflow)
    );

    // checks
    `DNLE_ASSERT_IMP(a_inflight_bound, 1'b1, inflight <= 3'd2,
                     "more than two labels outstanding")
    `DNLE_ASSERT_IMP(a_push_not_full, cmd_push, !q_stat.full,
                     "command pushed into a full queue")
    `DNLE_ASSERT_IMP(a_done_is_run_last, o_valid && o_name_done,
                     o_run_last && (o_label_count >= 8'd2),
                     "name end without run end or with too few labels")
    `DNLE_ASSERT_NXT(a_push_lands, cmd_push, !q_stat.empty,
                     "pushed command missing from queue")

endmodule
